// ===== sv/bf3e_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3e_pkg
// Shared constants and types of the 3x3 box filter with edge replication.
// ----------------------------------------------------------------------------
package bf3e_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_WIDTH_W   = 12;
  localparam int unsigned HEIGHT_W      = 16;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned WIDTH_RESET   = 640;
  localparam int unsigned HEIGHT_RESET  = 480;

  // nine 8-bit taps sum to at most 2295
  localparam int unsigned SUM_W      = 12;
  // floor(s / 9) == (s * 7282) >> 16 for every s up to 2295
  localparam int unsigned RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last_in_row;
    logic             last_in_frame;
  } res_t;

endpackage

// ===== sv/bf3e_cfg.sv =====
// ----------------------------------------------------------------------------
// bf3e_cfg
// Configuration registers; keeps the effective (clamped) width and height.
// ----------------------------------------------------------------------------
module bf3e_cfg #(
  parameter int unsigned MAX_WIDTH = bf3e_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WW        = $clog2(MAX_WIDTH + 2)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bf3e_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bf3e_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [WW-1:0]                       width_o,
  output logic [bf3e_pkg::HEIGHT_W-1:0]       height_o
);
  import bf3e_pkg::*;

  localparam int unsigned CMPW    = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
  localparam int unsigned W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [WW-1:0]       width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [CMPW-1:0]     raw_w;
  logic [HEIGHT_W-1:0] raw_h;

  assign cfg_ready_o = 1'b1;
  assign raw_w = CMPW'(cfg_data_i[CFG_WIDTH_W-1:0]);
  assign raw_h = cfg_data_i[HEIGHT_W-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          if (raw_w == '0) begin
            width_d = WW'(1);
          end else if (raw_w > CMPW'(MAX_WIDTH)) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(raw_w);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = (raw_h == '0) ? HEIGHT_W'(1) : raw_h;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RESET);
      height_q <= HEIGHT_W'(HEIGHT_RESET);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q != '0 && width_q <= WW'(MAX_WIDTH))
    else $error("effective width out of range");

  a_height_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    height_q != '0)
    else $error("effective height is zero");

  a_width_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CFG_IMAGE_HEIGHT |=> $stable(width_q))
    else $error("height write changed width");

endmodule

// ===== sv/bf3e_line_buf.sv =====
// ----------------------------------------------------------------------------
// bf3e_line_buf
// Two line memories with registered read and a bypass for a write and a read
// of the same column at the same edge.
// ----------------------------------------------------------------------------
module bf3e_line_buf #(
  parameter int unsigned MAX_WIDTH = bf3e_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [bf3e_pkg::PIX_W-1:0]    wr_above_i,
  input  logic [bf3e_pkg::PIX_W-1:0]    wr_middle_i,
  output logic [bf3e_pkg::PIX_W-1:0]    top_o,
  output logic [bf3e_pkg::PIX_W-1:0]    mid_o
);
  import bf3e_pkg::*;

  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_top_q, rd_mid_q;
  logic [PIX_W-1:0] fwd_top_q, fwd_mid_q;
  logic             fwd_q;
  logic             collide;

  assign collide = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      above_mem[wr_addr_i]  <= wr_above_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_top_q  <= above_mem[rd_addr_i];
      rd_mid_q  <= middle_mem[rd_addr_i];
      fwd_top_q <= wr_above_i;
      fwd_mid_q <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= collide;
    end
  end

  assign top_o = fwd_q ? fwd_top_q : rd_top_q;
  assign mid_o = fwd_q ? fwd_mid_q : rd_mid_q;

  a_fwd_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && collide |=> fwd_q)
    else $error("same-column read missed the bypass");

  a_fwd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_en_i |=> $stable(fwd_q))
    else $error("bypass flag changed without a read");

  a_fwd_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i && !collide |=> !fwd_q)
    else $error("bypass taken without a collision");

endmodule

// ===== sv/bf3e_window.sv =====
// ----------------------------------------------------------------------------
// bf3e_window
// 3x3 window, output position counters and the edge-replicated tap sum.
// ----------------------------------------------------------------------------
module bf3e_window #(
  parameter int unsigned MAX_WIDTH = bf3e_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int unsigned WW        = $clog2(MAX_WIDTH + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [bf3e_pkg::PIX_W-1:0]    top_i,
  input  logic [bf3e_pkg::PIX_W-1:0]    mid_i,
  input  logic [bf3e_pkg::PIX_W-1:0]    pix_i,
  input  logic [WW-1:0]                 width_i,
  input  logic [bf3e_pkg::HEIGHT_W-1:0] height_i,
  output logic                          res_valid_o,
  output bf3e_pkg::res_t                res_o,
  output logic                          frame_done_o
);
  import bf3e_pkg::*;

  logic [PIX_W-1:0]    win_q [9];
  logic [PIX_W-1:0]    win_d [9];
  logic [AW-1:0]       out_col_q, out_col_d, out_col_eff;
  logic [HEIGHT_W-1:0] out_row_q, out_row_d;
  logic [WW-1:0]       slot_q, slot_d;
  logic                has_result, last_col, last_row;
  logic [1:0]          left, right;
  logic [1:0]          sr [3];
  logic [SUM_W-1:0]    sum;

  assign out_col_eff = (WW'(out_col_q) >= width_i) ? '0 : out_col_q;
  assign has_result  = slot_q >= (width_i + WW'(1));
  assign last_col    = WW'(out_col_eff) >= (width_i - WW'(1));
  assign last_row    = out_row_q >= (height_i - HEIGHT_W'(1));
  assign left        = (out_col_eff == '0) ? 2'd1 : 2'd0;
  assign right       = last_col ? 2'd1 : 2'd2;
  assign sr[0]       = (out_row_q == '0) ? 2'd1 : 2'd0;
  assign sr[1]       = 2'd1;
  assign sr[2]       = last_row ? 2'd1 : 2'd2;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = pix_i;
  end

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      sum = sum + SUM_W'(win_d[4'(sr[r]) * 4'd3 + 4'(left)])
                + SUM_W'(win_d[4'(sr[r]) * 4'd3 + 4'd1])
                + SUM_W'(win_d[4'(sr[r]) * 4'd3 + 4'(right)]);
    end
  end

  always_comb begin
    out_col_d = out_col_eff;
    out_row_d = out_row_q;
    slot_d    = slot_q;
    if (has_result) begin
      if (last_col) begin
        out_col_d = '0;
        out_row_d = out_row_q + HEIGHT_W'(1);
      end else begin
        out_col_d = out_col_eff + AW'(1);
      end
    end else begin
      slot_d = slot_q + WW'(1);
    end
    if (has_result && last_col && last_row) begin
      out_col_d = '0;
      out_row_d = '0;
      slot_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      out_col_q <= '0;
      out_row_q <= '0;
      slot_q    <= '0;
    end else if (go_i) begin
      win_q     <= win_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      slot_q    <= slot_d;
    end
  end

  assign res_valid_o         = go_i && has_result;
  assign res_o.sum           = sum;
  assign res_o.last_in_row   = last_col;
  assign res_o.last_in_frame = last_col && last_row;
  assign frame_done_o        = has_result && last_col && last_row;

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && frame_done_o |=> slot_q == '0 && out_row_q == '0 && out_col_q == '0)
    else $error("frame end left counters set");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> sum <= SUM_W'(2295))
    else $error("tap sum out of range");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_i |=> $stable(slot_q) && $stable(out_col_q) && $stable(out_row_q))
    else $error("counters moved without an item");

endmodule

// ===== sv/bf3e_out.sv =====
// ----------------------------------------------------------------------------
// bf3e_out
// Sum register, divide by nine through a reciprocal, and the output register.
// ----------------------------------------------------------------------------
module bf3e_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_valid_i,
  output logic                       res_ready_o,
  input  bf3e_pkg::res_t             res_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bf3e_pkg::PIX_W-1:0] pixel_out_o,
  output logic                       last_in_row_o,
  output logic                       last_in_frame_o
);
  import bf3e_pkg::*;

  localparam int unsigned MULW = SUM_W + RECIP_W;

  logic             s2_valid_q;
  res_t             s2_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q;
  logic             last_row_q, last_frame_q;
  logic             out_adv;
  logic [MULW-1:0]  prod;

  assign out_adv     = !out_valid_q || out_ready_i;
  assign res_ready_o = !s2_valid_q || out_adv;
  assign prod        = MULW'(s2_q.sum) * MULW'(DIV9_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready_o) begin
        s2_valid_q <= res_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      s2_q <= res_i;
    end
    if (out_adv && s2_valid_q) begin
      pixel_q      <= prod[DIV9_SHIFT +: PIX_W];
      last_row_q   <= s2_q.last_in_row;
      last_frame_q <= s2_q.last_in_frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = pixel_q;
  assign last_in_row_o   = last_row_q;
  assign last_in_frame_o = last_frame_q;

  a_s2_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_adv |=> out_valid_q)
    else $error("sum stage item lost");

  a_s2_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_adv |=> s2_valid_q && $stable(s2_q))
    else $error("stalled sum stage changed");

  a_frame_has_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_q.last_in_frame |-> s2_q.last_in_row)
    else $error("frame end without row end");

endmodule

// ===== sv/box_filter_3x3_edge_replicate_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_replicate_core
// 3x3 mean filter with edge replication over one 8-bit image plane.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel (valid/ready); op_i marks a
// drain item, which acts as a pixel of value zero. Each result on the out
// channel is floor(sum of the 3x3 neighborhood / 9) with last_in_row_o and
// last_in_frame_o flags. Output (r,c) is caused by input (r+1,c+1), so after
// the W*H pixels of a frame the sender gives W+1 drain items.
// Throughput is one item per cycle while the output is not stalled: the two
// line memories are read at accept and written as the item leaves the tap
// stage, with a bypass for same-column back-to-back items. An item passes the
// tap and sum stages into the output register, which a stalled receiver holds;
// the sum and tap stages keep taking items until they fill, then in_ready_o
// drops. The configuration port is always ready and is to be written only
// while idle; the block itself does not enforce this. Reset clears the window,
// counters and handshake state; line memories are not cleared and need none.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_replicate_core #(
  parameter int unsigned MAX_WIDTH = bf3e_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bf3e_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bf3e_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [bf3e_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bf3e_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            last_in_row_o,
  output logic                            last_in_frame_o
);
  import bf3e_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 2);

  logic [WW-1:0]       width;
  logic [HEIGHT_W-1:0] height;
  logic                accept, s1_go, div_ready, frame_done, res_valid;
  logic                s1_valid_q;
  logic [PIX_W-1:0]    s1_pix_q;
  logic [AW-1:0]       s1_addr_q;
  logic [AW-1:0]       in_col_q, in_col_d, col_base, rd_addr;
  logic [WW-1:0]       rd_next;
  logic [PIX_W-1:0]    top, mid, pix;
  res_t                res;

  bf3e_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .WW        (WW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .width_o     (width),
    .height_o    (height)
  );

  assign s1_go      = s1_valid_q && div_ready;
  assign in_ready_o = !s1_valid_q || div_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign pix        = (op_e'(op_i) == OP_DRAIN) ? '0 : pixel_in_i;

  // column of the item being accepted; a frame that ends this edge restarts it
  assign col_base = (s1_go && frame_done) ? '0 : in_col_q;
  assign rd_addr  = (WW'(col_base) >= width) ? '0 : col_base;
  assign rd_next  = WW'(rd_addr) + WW'(1);

  always_comb begin
    in_col_d = in_col_q;
    if (accept) begin
      in_col_d = (rd_next >= width) ? '0 : AW'(rd_next);
    end else if (s1_go && frame_done) begin
      in_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      in_col_q   <= '0;
    end else begin
      in_col_q <= in_col_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix;
      s1_addr_q <= rd_addr;
    end
  end

  bf3e_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (rd_addr),
    .wr_en_i     (s1_go),
    .wr_addr_i   (s1_addr_q),
    .wr_above_i  (mid),
    .wr_middle_i (s1_pix_q),
    .top_o       (top),
    .mid_o       (mid)
  );

  bf3e_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW),
    .WW        (WW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (s1_go),
    .top_i        (top),
    .mid_i        (mid),
    .pix_i        (s1_pix_q),
    .width_i      (width),
    .height_i     (height),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .frame_done_o (frame_done)
  );

  bf3e_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_ready_o     (div_ready),
    .res_i           (res),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_o     (pixel_out_o),
    .last_in_row_o   (last_in_row_o),
    .last_in_frame_o (last_in_frame_o)
  );

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> WW'(rd_addr) < width)
    else $error("line memory column out of range");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !div_ready |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_addr_q))
    else $error("stalled tap stage changed");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && frame_done && !accept |=> in_col_q == '0)
    else $error("column not restarted at frame end");

endmodule

// ===== tb/tb_box_filter_3x3_edge_replicate_core.sv =====
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_edge_replicate_core
// Self-checking bench for the streaming 3x3 box filter with edge replication.
// ----------------------------------------------------------------------------
// Pixel planes are pushed through the in channel under random valid and ready
// gaps. A behavioral copy of the line buffers, the window and the row and
// column counters works out each mean as its item is accepted, and every
// result on the out channel is compared in order with those means. A short
// table of hand-checked frames comes first. Random frames of many shapes
// follow, most of them complete frames with their drain items and some of
// them loose runs of pixels and drains. The run ends with a mid-frame height
// change on a very tall plane and with a width write beyond the line length.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_edge_replicate_core;
  import bf3e_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 650;
  localparam int unsigned DIR_N       = 21;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             lir;
    logic             lif;
  } mean_item_t;

  typedef struct packed {
    op_e              op;
    logic [PIX_W-1:0] pix;
    logic             typed;
    logic [PIX_W-1:0] w_pix;
    logic             w_lir;
    logic             w_lif;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b1, 8'd255, 1'b0, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b1, 8'd255, 1'b1, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b1, 8'd255, 1'b0, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b1, 8'd255, 1'b1, 1'b1},
    '{OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd0,   1'b1, 8'd0,   1'b0, 1'b0},
    '{OP_DRAIN, 8'd255, 1'b1, 8'd0,   1'b1, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b1, 8'd0,   1'b0, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b1, 8'd0,   1'b1, 1'b1},
    // drain inside the frame, then a pixel after the frame's last pixel
    '{OP_PIXEL, 8'd10,  1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_DRAIN, 8'd200, 1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd30,  1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd40,  1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_PIXEL, 8'd99,  1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0, 1'b0},
    '{OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0, 1'b0}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  op_i        = OP_PIXEL;
  logic [PIX_W-1:0]      pixel_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  last_in_row_o;
  logic                  last_in_frame_o;

  box_filter_3x3_edge_replicate_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .last_in_row_o  (last_in_row_o),
    .last_in_frame_o(last_in_frame_o)
  );

  // filter state as the block should hold it
  bit [PIX_W-1:0]       lb_top [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]       lb_mid [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]       win [9];
  int unsigned          pcol_in, prow_in, pcol_out, prow_out, pslots;
  logic [CFG_WIDTH_W-1:0] reg_w = CFG_WIDTH_W'(WIDTH_RESET);
  logic [HEIGHT_W-1:0]    reg_h = HEIGHT_W'(HEIGHT_RESET);

  mean_item_t  mean_q [$];
  mean_item_t  pin_val;
  bit          pin_valid = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned tx_mode   = 0;
  int unsigned rx_mode   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fails     = 0;
  int unsigned n_pushed  = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_phases  = 0;

  function automatic int unsigned eff_w_of(input int unsigned w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned eff_h_of(input int unsigned h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic bit box_mean_step(input op_e op, input logic [PIX_W-1:0] pix,
                                       output mean_item_t res);
    int unsigned  w, h, left, right, sum, sr;
    bit [PIX_W-1:0] v, top, mid;
    bit           last_col, last_row, done, emit;
    w = eff_w_of(reg_w);
    h = eff_h_of(reg_h);
    v = (op == OP_DRAIN) ? '0 : pix;
    if (pcol_in >= w) pcol_in = 0;
    if (pcol_out >= w) pcol_out = 0;
    top = lb_top[pcol_in];
    mid = lb_mid[pcol_in];
    lb_top[pcol_in] = mid;
    lb_mid[pcol_in] = v;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    res  = '0;
    emit = 1'b0;
    done = 1'b0;
    if (pslots >= w + 1) begin
      left     = (pcol_out == 0) ? 1 : 0;
      last_col = pcol_out >= w - 1;
      last_row = prow_out >= h - 1;
      right    = last_col ? 1 : 2;
      sum      = 0;
      for (int r = 0; r < 3; r++) begin
        sr = r;
        if (r == 0 && prow_out == 0) sr = 1;
        if (r == 2 && last_row) sr = 1;
        sum += win[sr*3+left] + win[sr*3+1] + win[sr*3+right];
      end
      res.pix = PIX_W'(sum / 9);
      res.lir = last_col;
      res.lif = last_col && last_row;
      emit    = 1'b1;
      done    = last_col && last_row;
      if (last_col) begin
        pcol_out = 0;
        prow_out = (prow_out + 1) & 16'hFFFF;
      end else begin
        pcol_out++;
      end
    end
    if (pcol_in + 1 >= w) begin
      pcol_in = 0;
      prow_in = (prow_in + 1) & 16'hFFFF;
    end else begin
      pcol_in++;
    end
    if (pslots < w + 1) pslots++;
    if (done) begin
      pcol_in  = 0;
      prow_in  = 0;
      pcol_out = 0;
      prow_out = 0;
      pslots   = 0;
    end
    return emit;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // monitor: results first, then new items and register writes
  always @(posedge clk_i) begin : monitor
    mean_item_t want, res;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (mean_q.size() == 0) begin
          $error("unexpected item: pixel_out %0d, last_in_row %0b, last_in_frame %0b",
                 pixel_out_o, last_in_row_o, last_in_frame_o);
          fails++;
        end else begin
          want = mean_q.pop_front();
          n_checked++;
          if (pixel_out_o !== want.pix) begin
            $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out_o);
            fails++;
          end
          if (last_in_row_o !== want.lir) begin
            $error("last_in_row: expected %0b, got %0b", want.lir, last_in_row_o);
            fails++;
          end
          if (last_in_frame_o !== want.lif) begin
            $error("last_in_frame: expected %0b, got %0b", want.lif, last_in_frame_o);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        n_accepted++;
        if (box_mean_step(op_e'(op_i), pixel_in_i, res)) begin
          if (pin_valid) res = pin_val;
          mean_q = {mean_q, res};
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:  reg_w = cfg_data_i[CFG_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: reg_h = cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    int unsigned r;
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (rx_mode == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall = $urandom_range(10, 40);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= (r >= 30);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style);
    case (style)
      1:       return 8'd255;
      2:       return 8'd0;
      3:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_item(input op_e op, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    n_pushed++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (mean_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain items until the frame in progress has closed
  task automatic align_frame();
    while (pslots != 0) push_item(OP_DRAIN, PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input int unsigned style);
    int unsigned ew, eh;
    ew = eff_w_of(reg_w);
    eh = eff_h_of(reg_h);
    for (int unsigned i = 0; i < ew * eh; i++) push_item(OP_PIXEL, pick_pixel(style));
    for (int unsigned i = 0; i <= ew; i++) push_item(OP_DRAIN, PIX_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned w, h, r, ew, eh, nfr, nnoise, style;
    logic [3:0]  hi;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    tx_mode = $urandom_range(0, 1);
    rx_mode = $urandom_range(0, 1);
    foreach (DIR_ROWS[i]) begin
      pin_valid = DIR_ROWS[i].typed;
      pin_val   = '{DIR_ROWS[i].w_pix, DIR_ROWS[i].w_lir, DIR_ROWS[i].w_lif};
      push_item(DIR_ROWS[i].op, DIR_ROWS[i].pix);
    end
    pin_valid = 1'b0;
    align_frame();

    while (n_pushed < DIR_N + RAND_ITEMS) begin
      wait_drained();
      r = $urandom_range(0, 99);
      if (r < 8) w = 0;
      else if (r < 16) w = 1;
      else if (r < 90) w = $urandom_range(2, 10);
      else w = $urandom_range(11, 40);
      r = $urandom_range(0, 99);
      if (r < 10) h = 0;
      else if (r < 20) h = 1;
      else h = $urandom_range(2, 5);
      if (w > 10) h = $urandom_range(1, 2);
      if (n_phases == 1) begin
        w = 8;
        h = 6;
      end
      hi = $urandom_range(0, 15);
      write_reg(CFG_IMAGE_WIDTH, {hi, CFG_WIDTH_W'(w)});
      write_reg(CFG_IMAGE_HEIGHT, HEIGHT_W'(h));
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      if (n_phases == 1) begin
        tx_mode  = 0;
        hold_req = 1'b1;
      end
      ew  = eff_w_of(w);
      eh  = eff_h_of(h);
      nfr = $urandom_range(1, 3);
      for (int unsigned f = 0; f < nfr; f++) begin
        if (n_phases == 1 || $urandom_range(0, 9) < 8) begin
          align_frame();
          style = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3);
          send_frame(style);
        end else begin
          nnoise = $urandom_range(1, 2 * ew * eh + 2);
          for (int unsigned k = 0; k < nnoise; k++)
            push_item(op_e'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
        end
      end
      align_frame();
      n_phases++;
    end

    // very tall plane, cut short by a height write in the middle of the frame
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 16'h0002);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    tx_mode = $urandom_range(0, 2);
    rx_mode = $urandom_range(0, 2);
    repeat (40) push_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 16'h0000);
    align_frame();

    // width register beyond the line length, then narrowed in the middle of the frame
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    tx_mode = 0;
    rx_mode = $urandom_range(0, 2);
    repeat (2) push_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 16'h0002);
    align_frame();

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("run covered %0d items and %0d checked means over %0d random phases",
             n_accepted, n_checked, n_phases);
    $display("plus %0d register writes, a long output hold-off, a tall plane and a wide one",
             n_cfg);
    if (fails == 0 && mean_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bf3e_pkg.sv
sv/bf3e_cfg.sv
sv/bf3e_line_buf.sv
sv/bf3e_window.sv
sv/bf3e_out.sv
sv/box_filter_3x3_edge_replicate_core.sv
tb/tb_box_filter_3x3_edge_replicate_core.sv
